/* rtl/msort_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package msort_pkg;

  localparam int DATA_W        = 32;
  localparam int MAX_ITEMS_DEF = 64;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } in_beat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     last_out;
    logic                     overflow;
  } out_beat_t;

endpackage

`default_nettype wire

/* rtl/merge_sorter.sv */
// Channel   Direction  Payload      Handshake
// in_       input      in_beat_t    in_valid / in_ready
// out_      output     out_beat_t   out_valid / out_ready
//
// Loading accepts one beat per cycle; in_ready is low from the last beat until the
// final result beat is taken.
// Sorting of n elements: ceil(log2 n) passes; each element is read from the two-port
// source buffer, then compared and written, and each run starts with a setup step.
// Each result beat is read from the buffer, then presented, and held while out_ready is low.
// Reset clears the sequencer, count and overflow flag; buffer contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module merge_sorter
  import msort_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_beat_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_beat_t      out_data
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int SW = CW + 1;

  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_MERGE = 3'd3;
  localparam logic [2:0] ST_OREAD = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic          src_sel_r, src_sel_nxt;
  logic [CW-1:0] w_r, w_nxt;
  logic [CW-1:0] lo_r, lo_nxt;
  logic [CW-1:0] mid_r, mid_nxt;
  logic [CW-1:0] hi_r, hi_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] k_r, k_nxt;

  logic [DATA_W-1:0]        buf0_r [MAX_ITEMS];
  logic [DATA_W-1:0]        buf1_r [MAX_ITEMS];
  logic signed [DATA_W-1:0] rd_a_r, rd_b_r;

  logic              wr_en, wr_sel, rd_en;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;

  logic [SW-1:0] n_ext, lo_w, lo_2w, w2;
  logic [CW-1:0] i_inc, j_inc, k_inc;
  logic          take_left, is_final;

  assign n_ext    = {1'b0, cnt_r};
  assign lo_w     = {1'b0, lo_r} + {1'b0, w_r};
  assign lo_2w    = {1'b0, lo_r} + {w_r, 1'b0};
  assign w2       = {w_r, 1'b0};
  assign i_inc    = i_r + CW'(1);
  assign j_inc    = j_r + CW'(1);
  assign k_inc    = k_r + CW'(1);
  assign take_left = (i_r < mid_r) && ((j_r == hi_r) || (rd_a_r <= rd_b_r));
  assign is_final = (i_inc == cnt_r);

  assign in_ready  = (state_r == ST_LOAD);
  assign out_valid = (state_r == ST_OUT);
  assign out_data.sorted_value = rd_a_r;
  assign out_data.last_out     = is_final;
  assign out_data.overflow     = is_final & ovf_r;

  assign rd_en = (state_r == ST_READ) || (state_r == ST_OREAD);

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    ovf_nxt     = ovf_r;
    src_sel_nxt = src_sel_r;
    w_nxt       = w_r;
    lo_nxt      = lo_r;
    mid_nxt     = mid_r;
    hi_nxt      = hi_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    k_nxt       = k_r;
    wr_en       = 1'b0;
    wr_sel      = 1'b0;
    wr_addr     = k_r[AW-1:0];
    wr_data     = take_left ? rd_a_r : rd_b_r;
    case (state_r)
      ST_LOAD: begin
        wr_addr = cnt_r[AW-1:0];
        wr_data = in_data.value;
        if (in_valid) begin
          if (cnt_r < CW'(MAX_ITEMS)) begin
            wr_en   = 1'b1;
            cnt_nxt = cnt_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_data.last) begin
            src_sel_nxt = 1'b0;
            w_nxt       = CW'(1);
            lo_nxt      = '0;
            i_nxt       = '0;
            state_nxt   = (cnt_nxt > CW'(1)) ? ST_SETUP : ST_OREAD;
          end
        end
      end
      ST_SETUP: begin
        mid_nxt   = (lo_w > n_ext) ? cnt_r : lo_w[CW-1:0];
        hi_nxt    = (lo_2w > n_ext) ? cnt_r : lo_2w[CW-1:0];
        i_nxt     = lo_r;
        j_nxt     = mid_nxt;
        k_nxt     = lo_r;
        state_nxt = ST_READ;
      end
      ST_READ: begin
        state_nxt = ST_MERGE;
      end
      ST_MERGE: begin
        wr_en  = 1'b1;
        wr_sel = ~src_sel_r;
        k_nxt  = k_inc;
        if (take_left) begin
          i_nxt = i_inc;
        end else begin
          j_nxt = j_inc;
        end
        state_nxt = ST_READ;
        if (k_inc == hi_r) begin
          state_nxt = ST_SETUP;
          lo_nxt    = hi_r;
          if (hi_r == cnt_r) begin
            src_sel_nxt = ~src_sel_r;
            w_nxt       = w2[CW-1:0];
            lo_nxt      = '0;
            if (w2 >= n_ext) begin
              i_nxt     = '0;
              state_nxt = ST_OREAD;
            end
          end
        end
      end
      ST_OREAD: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) begin
          if (is_final) begin
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
            state_nxt = ST_LOAD;
          end else begin
            i_nxt     = i_inc;
            state_nxt = ST_OREAD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_sel_r <= src_sel_nxt;
    w_r       <= w_nxt;
    lo_r      <= lo_nxt;
    mid_r     <= mid_nxt;
    hi_r      <= hi_nxt;
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    k_r       <= k_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (wr_sel) begin
        buf1_r[wr_addr] <= wr_data;
      end else begin
        buf0_r[wr_addr] <= wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a_r <= src_sel_r ? buf1_r[i_r[AW-1:0]] : buf0_r[i_r[AW-1:0]];
      rd_b_r <= src_sel_r ? buf1_r[j_r[AW-1:0]] : buf0_r[j_r[AW-1:0]];
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and output open together");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_ITEMS))
    else $error("element count above capacity");

  a_merge_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MERGE) |-> (k_r < hi_r) && (hi_r <= cnt_r))
    else $error("merge write outside run");

  a_final_returns: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_data.last_out) |=> in_ready && (cnt_r == '0))
    else $error("final beat did not return to load");

  a_ovf_only_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.overflow) |-> out_data.last_out)
    else $error("overflow on non-final beat");

endmodule

`default_nettype wire
